### hdl/tdf_pkg.sv
// ----------------------------------------------------------------------------
// tdf_pkg
// Shared widths, codes and controller/datapath interface types for the
// trial-division factorizer.
// ----------------------------------------------------------------------------
package tdf_pkg;

	localparam int WIDTH     = 32;
	localparam int VALUE_W   = 32;
	localparam int PRIME_W   = 32;
	localparam int EXP_W     = 5;
	localparam int D_W       = (WIDTH + 1) / 2 + 1;
	localparam int SQ_W      = 2 * D_W;
	localparam int MAX_PAIRS = 9;
	localparam int CNT_W     = $clog2(MAX_PAIRS + 1);
	localparam int DCNT_W    = $clog2(WIDTH);

	localparam logic [D_W-1:0]     D_FIRST    = D_W'(2);
	localparam logic [D_W-1:0]     D_SECOND   = D_W'(3);
	localparam logic [D_W-1:0]     D_STEP     = D_W'(2);
	localparam logic [PRIME_W-1:0] UNIT_PRIME = PRIME_W'(2);
	localparam logic [EXP_W-1:0]   EXP_SAT    = {EXP_W{1'b1}};
	localparam logic [EXP_W-1:0]   EXP_ONE    = EXP_W'(1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLASS,
		ST_EMIT_ZERO,
		ST_EMIT_ONE,
		ST_SQR,
		ST_CHK,
		ST_DSTART,
		ST_DIV,
		ST_PUSH,
		ST_END
	} state_t;

	typedef enum logic [1:0] {
		OSEL_PEND,
		OSEL_REM,
		OSEL_ZERO,
		OSEL_ONE
	} osel_t;

	typedef struct packed {
		logic  load;
		logic  div_start;
		logic  take_q;
		logic  next_d;
		logic  push;
		logic  pend_clr;
		logic  out_load;
		logic  out_last;
		osel_t osel;
	} dp_cmd_t;

	typedef struct packed {
		logic n_is0;
		logic n_is1;
		logic n_gt1;
		logic sq_gt_n;
		logic div_done;
		logic rem_zero;
		logic e_nz;
		logic pend_v;
		logic cnt_full;
		logic slot_free;
	} dp_stat_t;

endpackage

### hdl/tdf_div.sv
// ----------------------------------------------------------------------------
// tdf_div
// Restoring divider, one quotient bit per cycle; done pulses on the same edge
// that shifts in the last bit.
// ----------------------------------------------------------------------------
module tdf_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [tdf_pkg::WIDTH-1:0]  dividend,
	input  logic [tdf_pkg::D_W-1:0]    divisor,
	output logic [tdf_pkg::WIDTH-1:0]  quotient,
	output logic [tdf_pkg::D_W-1:0]    remainder,
	output logic                       done
);
	import tdf_pkg::*;

	logic [WIDTH-1:0]  q_q;
	logic [D_W-1:0]    p_q;
	logic [D_W-1:0]    dvsr_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [D_W:0]   trial;
	logic [D_W:0]   diff;
	logic           ge;
	logic [D_W-1:0] p_nx;

	always_comb begin
		trial = {p_q, q_q[WIDTH-1]};
		diff  = trial - {1'b0, dvsr_q};
		ge    = trial >= {1'b0, dvsr_q};
		p_nx  = ge ? diff[D_W-1:0] : trial[D_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(WIDTH - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - DCNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q    <= dividend;
			p_q    <= '0;
			dvsr_q <= divisor;
		end else if (busy_q) begin
			q_q <= {q_q[WIDTH-2:0], ge};
			p_q <= p_nx;
		end
	end

	assign quotient  = q_q;
	assign remainder = p_q;
	assign done      = done_q;

endmodule

### hdl/tdf_datapath.sv
// ----------------------------------------------------------------------------
// tdf_datapath
// Remaining value, candidate divisor and its square, exponent and pair
// counters, one pending pair and the output register.
// ----------------------------------------------------------------------------
module tdf_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tdf_pkg::dp_cmd_t            cmd,
	output tdf_pkg::dp_stat_t           stat,
	input  logic [tdf_pkg::VALUE_W-1:0] value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [tdf_pkg::PRIME_W-1:0] prime,
	output logic [tdf_pkg::EXP_W-1:0]   exponent,
	output logic                        is_empty,
	output logic                        last
);
	import tdf_pkg::*;

	logic [WIDTH-1:0]   n_q;
	logic [D_W-1:0]     d_q;
	logic [SQ_W-1:0]    sq_q;
	logic [EXP_W-1:0]   e_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [D_W-1:0]     pend_prime_q;
	logic [EXP_W-1:0]   pend_exp_q;
	logic               pend_v_q;
	logic               out_valid_q;
	logic [PRIME_W-1:0] prime_q;
	logic [EXP_W-1:0]   exponent_q;
	logic               is_empty_q;
	logic               last_q;

	logic [WIDTH-1:0] div_quot;
	logic [D_W-1:0]   div_rem;
	logic             div_done;

	logic [PRIME_W-1:0] prime_nx;
	logic [EXP_W-1:0]   exp_nx;
	logic               empty_nx;

	tdf_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (n_q),
		.divisor   (d_q),
		.quotient  (div_quot),
		.remainder (div_rem),
		.done      (div_done)
	);

	always_ff @(posedge clk) begin
		sq_q <= d_q * d_q;
		if (cmd.load) begin
			n_q <= WIDTH'(value);
		end else if (cmd.take_q) begin
			n_q <= div_quot;
		end
		if (cmd.load) begin
			d_q <= D_FIRST;
		end else if (cmd.next_d) begin
			d_q <= (d_q == D_FIRST) ? D_SECOND : d_q + D_STEP;
		end
		if (cmd.load || cmd.push) begin
			e_q <= '0;
		end else if (cmd.take_q && e_q != EXP_SAT) begin
			e_q <= e_q + EXP_ONE;
		end
		if (cmd.push) begin
			pend_prime_q <= d_q;
			pend_exp_q   <= e_q;
		end
		if (cmd.out_load) begin
			prime_q    <= prime_nx;
			exponent_q <= exp_nx;
			is_empty_q <= empty_nx;
			last_q     <= cmd.out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.push) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.load || cmd.pend_clr) begin
				pend_v_q <= 1'b0;
			end else if (cmd.push) begin
				pend_v_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		unique case (cmd.osel)
			OSEL_PEND: begin
				prime_nx = PRIME_W'(pend_prime_q);
				exp_nx   = pend_exp_q;
				empty_nx = 1'b0;
			end
			OSEL_REM: begin
				prime_nx = PRIME_W'(n_q);
				exp_nx   = EXP_ONE;
				empty_nx = 1'b0;
			end
			OSEL_ZERO: begin
				prime_nx = '0;
				exp_nx   = '0;
				empty_nx = 1'b1;
			end
			OSEL_ONE: begin
				prime_nx = UNIT_PRIME;
				exp_nx   = '0;
				empty_nx = 1'b0;
			end
			default: begin
				prime_nx = '0;
				exp_nx   = '0;
				empty_nx = 1'b0;
			end
		endcase
	end

	always_comb begin
		stat.n_is0     = n_q == '0;
		stat.n_is1     = n_q == WIDTH'(1);
		stat.n_gt1     = n_q > WIDTH'(1);
		stat.sq_gt_n   = sq_q > SQ_W'(n_q);
		stat.div_done  = div_done;
		stat.rem_zero  = div_rem == '0;
		stat.e_nz      = e_q != '0;
		stat.pend_v    = pend_v_q;
		stat.cnt_full  = cnt_q == CNT_W'(MAX_PAIRS);
		stat.slot_free = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign prime     = prime_q;
	assign exponent  = exponent_q;
	assign is_empty  = is_empty_q;
	assign last      = last_q;

endmodule

### hdl/tdf_ctrl.sv
// ----------------------------------------------------------------------------
// tdf_ctrl
// Sequencer for the trial-division loop: square check, repeated division,
// pair hand-off and end-of-run flush.
// ----------------------------------------------------------------------------
module tdf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output tdf_pkg::dp_cmd_t   cmd,
	input  tdf_pkg::dp_stat_t  stat
);
	import tdf_pkg::*;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nx = ST_CLASS;
			end
			ST_CLASS: begin
				if (stat.n_is0) state_nx = ST_EMIT_ZERO;
				else if (stat.n_is1) state_nx = ST_EMIT_ONE;
				else state_nx = ST_SQR;
			end
			ST_EMIT_ZERO, ST_EMIT_ONE: begin
				if (stat.slot_free) state_nx = ST_IDLE;
			end
			ST_SQR: state_nx = ST_CHK;
			ST_CHK: begin
				if (stat.cnt_full || stat.sq_gt_n) state_nx = ST_END;
				else state_nx = ST_DIV;
			end
			ST_DSTART: state_nx = ST_DIV;
			ST_DIV: begin
				if (stat.div_done) begin
					if (stat.rem_zero) state_nx = ST_DSTART;
					else if (stat.e_nz) state_nx = ST_PUSH;
					else state_nx = ST_SQR;
				end
			end
			ST_PUSH: begin
				if (!stat.pend_v || stat.slot_free) state_nx = ST_SQR;
			end
			ST_END: begin
				if (stat.n_gt1 && !stat.cnt_full) begin
					if (!stat.pend_v && stat.slot_free) state_nx = ST_IDLE;
				end else if (stat.slot_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.osel = OSEL_PEND;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_EMIT_ZERO: begin
				cmd.out_load = stat.slot_free;
				cmd.out_last = 1'b1;
				cmd.osel     = OSEL_ZERO;
			end
			ST_EMIT_ONE: begin
				cmd.out_load = stat.slot_free;
				cmd.out_last = 1'b1;
				cmd.osel     = OSEL_ONE;
			end
			ST_CHK: begin
				cmd.div_start = !(stat.cnt_full || stat.sq_gt_n);
			end
			ST_DSTART: begin
				cmd.div_start = 1'b1;
			end
			ST_DIV: begin
				cmd.take_q = stat.div_done && stat.rem_zero;
				cmd.next_d = stat.div_done && !stat.rem_zero && !stat.e_nz;
			end
			ST_PUSH: begin
				if (!stat.pend_v || stat.slot_free) begin
					cmd.push     = 1'b1;
					cmd.next_d   = 1'b1;
					cmd.out_load = stat.pend_v;
				end
			end
			ST_END: begin
				if (stat.n_gt1 && !stat.cnt_full) begin
					if (stat.pend_v) begin
						cmd.out_load = stat.slot_free;
						cmd.pend_clr = stat.slot_free;
					end else begin
						cmd.out_load = stat.slot_free;
						cmd.out_last = 1'b1;
						cmd.osel     = OSEL_REM;
					end
				end else begin
					cmd.out_load = stat.slot_free;
					cmd.pend_clr = stat.slot_free;
					cmd.out_last = 1'b1;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

### hdl/trial_division_factorizer_core.sv
// ----------------------------------------------------------------------------
// trial_division_factorizer_core
// Prime factorization by trial division; one (prime, exponent) pair per
// output transfer, last pair of a run flagged.
//
// channel  direction  handshake             payload
// in       sink       in_valid / in_stall   value
// out      source     out_valid / out_stall prime, exponent, is_empty, last
//
// One value at a time. Each candidate divisor goes through a square, a compare
// and a one-bit-per-cycle division, plus one further division each time it
// divides. Worst case about 32770 candidates for a 32-bit prime.
// Reset clears the sequencer and output valid; no memory to clear.
// A stalled output holds the search at the next pair hand-off.
// ----------------------------------------------------------------------------
module trial_division_factorizer_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [tdf_pkg::VALUE_W-1:0] value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [tdf_pkg::PRIME_W-1:0] prime,
	output logic [tdf_pkg::EXP_W-1:0]   exponent,
	output logic                        is_empty,
	output logic                        last
);
	import tdf_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     in_ready;

	tdf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	tdf_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.prime     (prime),
		.exponent  (exponent),
		.is_empty  (is_empty),
		.last      (last)
	);

	assign in_stall = !in_ready;

endmodule

### hdl/tdf_checker.sv
// ----------------------------------------------------------------------------
// tdf_checker
// Port-level checks for the factorizer, bound to the top level.
// ----------------------------------------------------------------------------
module tdf_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic [tdf_pkg::VALUE_W-1:0] value,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [tdf_pkg::PRIME_W-1:0] prime,
	input logic [tdf_pkg::EXP_W-1:0]   exponent,
	input logic                        is_empty,
	input logic                        last
);
	import tdf_pkg::*;

	// one value in flight: busy right after a transfer in
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while previous value still in work");

	a_empty_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_empty |-> last && prime == '0 && exponent == '0)
		else $error("empty pair malformed");

	a_unit_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_empty && exponent == '0 |-> prime == UNIT_PRIME && last)
		else $error("zero exponent outside unit input");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(prime) && $stable(exponent)
			&& $stable(is_empty) && $stable(last))
		else $error("stalled output changed");

	a_idle_value_seen: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && value == '0 |=> !out_valid || is_empty || !last
			|| $past(out_valid))
		else $error("zero input produced a non-empty final pair");

endmodule

bind trial_division_factorizer_core tdf_checker u_tdf_checker (.*);

### verif/trial_division_factorizer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_factorizer_core_tb
// Feeds integers to the factorizer and checks every (prime, exponent) pair
// against a trial-division predictor kept in a small scoreboard. Both sides
// idle at random; the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module trial_division_factorizer_core_tb;
	import tdf_pkg::*;

	localparam int CLK_HALF   = 6;
	localparam int RESET_CYC  = 7;
	localparam int RAND_ITEMS = 100;
	localparam int HOLD_AT    = 20;
	localparam int HOLD_CYC   = 400;
	localparam int TAIL_CYC   = 80;
	localparam int STALL_LIM  = 150000;

	typedef struct packed {
		logic [PRIME_W-1:0] prime;
		logic [EXP_W-1:0]   exponent;
		logic               is_empty;
		logic               last;
	} pair_t;

	class factor_scoreboard;
		pair_t pairs_due[$];
		int    errors;

		function pair_t make_pair(longint unsigned p, longint unsigned e, bit emp);
			pair_t r;
			r.prime    = p[PRIME_W-1:0];
			r.exponent = (e > EXP_SAT) ? EXP_SAT : e[EXP_W-1:0];
			r.is_empty = emp;
			r.last     = 1'b0;
			return r;
		endfunction

		// divide out each candidate while d*d fits in what is left
		function void add_value(logic [VALUE_W-1:0] v);
			longint unsigned rest;
			longint unsigned d;
			longint unsigned e;
			pair_t           run[$];
			pair_t           tip;
			rest = v;
			if (rest == 0) begin
				run.push_back(make_pair(0, 0, 1'b1));
			end else if (rest == 1) begin
				run.push_back(make_pair(UNIT_PRIME, 0, 1'b0));
			end else begin
				d = 2;
				while (d <= rest / d && run.size() < MAX_PAIRS) begin
					if (rest % d == 0) begin
						e = 0;
						while (rest % d == 0) begin
							rest = rest / d;
							e++;
						end
						run.push_back(make_pair(d, e, 1'b0));
					end
					d = (d == 2) ? 3 : d + 2;
				end
				if (rest > 1 && run.size() < MAX_PAIRS)
					run.push_back(make_pair(rest, 1, 1'b0));
			end
			tip = run.pop_back();
			tip.last = 1'b1;
			run.push_back(tip);
			foreach (run[i])
				pairs_due.push_back(run[i]);
		endfunction

		function void check_pair(pair_t got);
			pair_t want;
			if (pairs_due.size() == 0) begin
				$display("%0t: unexpected pair prime=%0d exponent=%0d is_empty=%0b last=%0b",
					$time, got.prime, got.exponent, got.is_empty, got.last);
				errors++;
				return;
			end
			want = pairs_due.pop_front();
			if (got.prime !== want.prime) begin
				$display("%0t: prime expected %0d actual %0d", $time, want.prime, got.prime);
				errors++;
			end
			if (got.exponent !== want.exponent) begin
				$display("%0t: exponent expected %0d actual %0d", $time,
					want.exponent, got.exponent);
				errors++;
			end
			if (got.is_empty !== want.is_empty) begin
				$display("%0t: is_empty expected %0b actual %0b", $time,
					want.is_empty, got.is_empty);
				errors++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [VALUE_W-1:0] value;
	logic               out_valid;
	logic               out_stall;
	logic [PRIME_W-1:0] prime;
	logic [EXP_W-1:0]   exponent;
	logic               is_empty;
	logic               last;

	factor_scoreboard sb = new();
	bit               burst_in;
	bit               burst_out;
	int               idle_cycles;

	trial_division_factorizer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.prime     (prime),
		.exponent  (exponent),
		.is_empty  (is_empty),
		.last      (last)
	);

	always begin
		clk = 1'b1;
		#CLK_HALF;
		clk = 1'b0;
		#CLK_HALF;
	end

	// in_valid stays high across back-to-back transfers
	task automatic send_value(input logic [VALUE_W-1:0] v);
		int gap;
		gap = burst_in ? 0 : $urandom_range(0, 9);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		sb.add_value(v);
	endtask

	// numbers with small prime factors keep the divisor search short
	function automatic logic [VALUE_W-1:0] random_value();
		longint unsigned n;
		longint unsigned f;
		int              mode;
		n    = 1;
		mode = $urandom_range(0, 9);
		case (mode)
			0, 1, 2, 3: begin
				do begin
					f = $urandom_range(2, 255);
					if (n * f > 64'hFFFF_FFFF)
						break;
					n = n * f;
				end while ($urandom_range(0, 15) != 0);
			end
			4, 5: begin
				n = $urandom_range(2, 20000);
				do begin
					f = $urandom_range(2, 31);
					if (n * f > 64'hFFFF_FFFF)
						break;
					n = n * f;
				end while ($urandom_range(0, 7) != 0);
			end
			6, 7: begin
				f = $urandom_range(2, 15);
				while (n * f <= 64'hFFFF_FFFF && $urandom_range(0, 11) != 0)
					n = n * f;
			end
			8: n = $urandom_range(0, 3);
			default: n = $urandom_range(0, 18'h3FFFF);
		endcase
		return n[VALUE_W-1:0];
	endfunction

	initial begin
		logic [VALUE_W-1:0] directed[$];
		arst_n   = 1'b0;
		in_valid = 1'b0;
		value    = '0;
		burst_in = 1'b0;
		directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'hFFFF_FFFF, 32'h8000_0000,
			32'd223092870, 32'd65521, 32'd1000003, 32'd3486784401, 32'hC000_0000,
			32'd1220703125, 32'd4294836225, 32'd999999999, 32'd1, 32'd0, 32'd49};
		repeat (RESET_CYC) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		foreach (directed[i])
			send_value(directed[i]);
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i % 16 == 0)
				burst_in = ($urandom_range(0, 2) == 0);
			send_value(random_value());
		end
		@(negedge clk);
		in_valid <= 1'b0;
		wait (sb.pairs_due.size() == 0);
		repeat (TAIL_CYC) @(posedge clk);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		int    gap;
		int    seen;
		pair_t got;
		out_stall = 1'b0;
		burst_out = 1'b0;
		seen      = 0;
		@(posedge arst_n);
		forever begin
			if (seen % 16 == 0)
				burst_out = ($urandom_range(0, 2) == 0);
			gap = burst_out ? 0 : $urandom_range(0, 9);
			@(negedge clk);
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (!out_valid);
			got.prime    = prime;
			got.exponent = exponent;
			got.is_empty = is_empty;
			got.last     = last;
			sb.check_pair(got);
			seen++;
			// long hold-off so the core backs up and stalls its input
			if (seen == HOLD_AT) begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (HOLD_CYC) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIM) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial idle_cycles = 0;

endmodule
